FILE: hw/rtl/phs_pkg.sv
// ----------------------------------------------------------------------------
// phs_pkg - shared definitions for the allpass phaser
// widths, register indexes, sequencer codes and the sample saturation helper
// ----------------------------------------------------------------------------
`default_nettype none

package phs_pkg;

  // sample format and filter length
  localparam int SAMPLE_BITS = 24;
  localparam int STAGES      = 4;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Q2.30 arithmetic
  localparam int Q_FRAC = 30;

  // digit-serial multiplier: signed A times signed B, one radix-16 digit of B per cycle
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 33;
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = (MUL_B_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MUL_BX_W   = MUL_DIGITS * DIGIT_W;
  localparam int MUL_ACC_W  = MUL_A_W + DIGIT_W + 1;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
  localparam int PROD_W     = MUL_ACC_W + MUL_BX_W;

  // rounded product and the saturating sums built on it
  localparam int RND_W = PROD_W - Q_FRAC;
  localparam int SUM_W = RND_W + 2;

  // bit-serial divider for the allpass coefficient
  localparam int DIV_N_W   = CFG_W;
  localparam int DIV_D_W   = CFG_W + 1;
  localparam int DIV_STEPS = Q_FRAC + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int STG_CNT_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  // register reset values
  localparam logic [CFG_W-1:0] SWEEP_LOW_RST  = 32'd76491118;
  localparam logic [CFG_W-1:0] SWEEP_HIGH_RST = 32'd313308201;
  localparam logic [CFG_W-1:0] STEP_UP_RST    = 32'd1086781344;
  localparam logic [CFG_W-1:0] STEP_DOWN_RST  = 32'd1060854775;
  localparam logic [CFG_W-1:0] GAIN_ONE       = CFG_W'(64'd1 << Q_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWEEP_LOW       = 3'd0,
    CFG_SWEEP_HIGH      = 3'd1,
    CFG_SWEEP_STEP_UP   = 3'd2,
    CFG_SWEEP_STEP_DOWN = 3'd3,
    CFG_FEEDBACK_GAIN   = 3'd4,
    CFG_DRY_GAIN        = 3'd5,
    CFG_WET_GAIN        = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MGO,
    S_MWAIT,
    S_RND,
    S_WB
  } phs_state_t;

  typedef enum logic [2:0] {
    OP_FB,
    OP_STG,
    OP_DRY,
    OP_WET,
    OP_SWEEP
  } phs_op_t;

  localparam logic signed [SUM_W-1:0] SMP_MAX =
    {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMP_MIN = ~SMP_MAX;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] res;
    if (v > SMP_MAX) begin
      res = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (v < SMP_MIN) begin
      res = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      res = v[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/phs_div.sv
// ----------------------------------------------------------------------------
// phs_div - bit-serial restoring divider
// quotient of (num_mag * 2^30) / den, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module phs_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [phs_pkg::DIV_N_W-1:0]          num_mag,
  input  logic [phs_pkg::DIV_D_W-1:0]          den,
  output logic                                 done,
  output logic [phs_pkg::DIV_STEPS-1:0]        quo
);
  import phs_pkg::*;

  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   den_r;
  logic [DIV_STEPS-1:0] nb_r;
  logic [DIV_STEPS-1:0] q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIV_D_W:0]     r2;
  logic [DIV_D_W:0]     diff;
  logic                 geq;
  logic                 last_step;

  // the dividend top bits already sit below the divisor, so 31 steps suffice
  assign r2        = {rem_r, nb_r[DIV_STEPS-1]};
  assign geq       = (r2 >= {1'b0, den_r});
  assign diff      = r2 - {1'b0, den_r};
  assign last_step = (cnt_r == DIV_CNT_W'(DIV_STEPS-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && !start && last_step;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIV_D_W'(num_mag[DIV_N_W-1:1]);
      nb_r  <= {num_mag[0], {(DIV_STEPS-1){1'b0}}};
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= geq ? diff[DIV_D_W-1:0] : r2[DIV_D_W-1:0];
      nb_r  <= nb_r << 1;
      q_r   <= {q_r[DIV_STEPS-2:0], geq};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/phs_mul.sv
// ----------------------------------------------------------------------------
// phs_mul - digit-serial signed multiplier
// one radix-16 digit of b per cycle, accumulator shifts right by a digit
// ----------------------------------------------------------------------------
`default_nettype none

module phs_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [phs_pkg::MUL_A_W-1:0]   a,
  input  logic signed [phs_pkg::MUL_B_W-1:0]   b,
  output logic                                 done,
  output logic signed [phs_pkg::PROD_W-1:0]    prod
);
  import phs_pkg::*;

  logic signed [MUL_A_W-1:0]   a_r;
  logic [MUL_BX_W-1:0]         b_r;
  logic signed [MUL_ACC_W-1:0] acc_r;
  logic [MUL_BX_W-1:0]         lo_r;
  logic [MUL_CNT_W-1:0]        cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic                        last_digit;
  logic signed [DIGIT_W:0]     digit;
  logic signed [MUL_ACC_W-1:0] pp;
  logic signed [MUL_ACC_W-1:0] sum;

  // top digit carries the sign of b
  assign last_digit = (cnt_r == MUL_CNT_W'(MUL_DIGITS-1));
  assign digit = last_digit ? $signed({b_r[DIGIT_W-1], b_r[DIGIT_W-1:0]})
                            : $signed({1'b0, b_r[DIGIT_W-1:0]});
  assign pp  = MUL_ACC_W'(a_r) * MUL_ACC_W'(digit);
  assign sum = acc_r + pp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && !start && last_digit;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_digit) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= MUL_BX_W'(b);
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= sum >>> DIGIT_W;
      lo_r  <= {sum[DIGIT_W-1:0], lo_r[MUL_BX_W-1:DIGIT_W]};
      b_r   <= b_r >> DIGIT_W;
    end
  end

  assign done = done_r;
  assign prod = $signed({acc_r, lo_r});

endmodule

`default_nettype wire

FILE: hw/rtl/phaser_allpass_sweep.sv
// ----------------------------------------------------------------------------
// phaser_allpass_sweep - mono phaser, four allpass stages with swept coefficient
// feedback, allpass chain, dry/wet mix and exponential sweep, all on shared
// serial arithmetic units
// ----------------------------------------------------------------------------
// each item takes the bit-serial coefficient divide, then 8 products, each of
//   9 digit steps plus issue, wait, round and write-back, on the single
//   digit-serial multiplier
// a new item is taken only once the sweep update of the previous one is done
// reset (synchronous, active low) loads all configuration registers with their defaults,
//   clears the allpass state and sets the sweep upward from the lower bound
`default_nettype none

module phaser_allpass_sweep (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input items
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [phs_pkg::SAMPLE_BITS-1:0] in_sample_in,
  // result items
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [phs_pkg::SAMPLE_BITS-1:0] out_sample_out,
  // register writes
  input  logic                                   cfg_we,
  input  logic [phs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [phs_pkg::CFG_W-1:0]              cfg_wdata
);
  import phs_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]        sweep_low_r;
  logic [CFG_W-1:0]        sweep_high_r;
  logic [CFG_W-1:0]        step_up_r;
  logic [CFG_W-1:0]        step_down_r;
  logic signed [CFG_W-1:0] fb_gain_r;
  logic signed [CFG_W-1:0] dry_gain_r;
  logic signed [CFG_W-1:0] wet_gain_r;

  // filter and sweep state; the stage arrays rotate so the stage in work is at 0
  logic signed [SAMPLE_BITS-1:0] so_r  [STAGES];
  logic signed [SAMPLE_BITS-1:0] spi_r [STAGES];
  logic [CFG_W-1:0]              p_r;
  logic                          desc_r;

  // per item working registers
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] v_r;
  logic signed [CFG_W-1:0]       k_r;
  logic signed [RND_W-1:0]       rnd_r;
  logic signed [PROD_W-1:0]      dry_prod_r;
  logic [STG_CNT_W-1:0]          stg_cnt_r;

  // result register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  // sequencer
  phs_state_t state_r, state_nxt;
  phs_op_t    op_r, op_nxt;

  // arithmetic units
  logic                          div_start;
  logic                          div_done;
  logic [DIV_STEPS-1:0]          div_quo;
  logic                          p_over;
  logic [DIV_N_W-1:0]            num_mag;
  logic [DIV_D_W-1:0]            den;
  logic [CFG_W-1:0]              kq;

  logic                          mul_start;
  logic                          mul_done;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      mul_prod;

  logic signed [PROD_W-1:0]      rnd_src;
  logic [PROD_W-1:0]             rnd_add;
  logic signed [SUM_W-1:0]       wb_sum;
  logic signed [SAMPLE_BITS-1:0] wb_sat;
  logic [CFG_W-1:0]              np;
  logic                          stg_last;
  logic                          out_free;
  logic                          wb_fire;
  logic                          in_acc;

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (Q_FRAC - 1);

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign stg_last = (stg_cnt_r == STG_CNT_W'(STAGES-1));
  assign wb_fire  = (state_r == S_WB) && ((op_r != OP_WET) || out_free);

  // ---------------------------------------------------------------------------
  // coefficient k = (1 - p) / (1 + p): magnitude divided serially, sign from p
  // ---------------------------------------------------------------------------
  assign p_over    = (p_r > GAIN_ONE);
  assign num_mag   = p_over ? (p_r - GAIN_ONE) : (GAIN_ONE - p_r);
  assign den       = {1'b0, p_r} + DIV_D_W'(GAIN_ONE);
  assign div_start = in_acc;
  assign kq        = CFG_W'(div_quo);

  phs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (num_mag),
    .den     (den),
    .done    (div_done),
    .quo     (div_quo)
  );

  // ---------------------------------------------------------------------------
  // multiplier operand select, one product per sequencer pass
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_FB: begin
        mul_a = MUL_A_W'(so_r[STAGES-1]);
        mul_b = MUL_B_W'(fb_gain_r);
      end
      OP_STG: begin
        mul_a = MUL_A_W'(v_r) + MUL_A_W'(so_r[0]);
        mul_b = MUL_B_W'(k_r);
      end
      OP_DRY: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = MUL_B_W'(dry_gain_r);
      end
      OP_WET: begin
        mul_a = MUL_A_W'(v_r);
        mul_b = MUL_B_W'(wet_gain_r);
      end
      OP_SWEEP: begin
        // unsigned sweep operands, zero extended
        mul_a = $signed({1'b0, p_r});
        mul_b = $signed({1'b0, desc_r ? step_down_r : step_up_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_r == S_MGO);

  phs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // ---------------------------------------------------------------------------
  // rounding: floor((prod + 2^29) / 2^30); the mix adds both products first
  // ---------------------------------------------------------------------------
  assign rnd_src = mul_prod + ((op_r == OP_WET) ? dry_prod_r : PROD_W'(0));
  assign rnd_add = rnd_src + RND_HALF;

  // write-back sum and saturation
  always_comb begin
    case (op_r)
      OP_FB:   wb_sum = SUM_W'(rnd_r) + SUM_W'(x_r);
      OP_STG:  wb_sum = SUM_W'(rnd_r) - SUM_W'(spi_r[0]);
      default: wb_sum = SUM_W'(rnd_r);
    endcase
  end

  assign wb_sat = sat_sample(wb_sum);

  // new sweep position, clamped to the 32 bit range
  assign np = (|rnd_r[RND_W-1:CFG_W]) ? {CFG_W{1'b1}} : rnd_r[CFG_W-1:0];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_FB;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MGO;
          op_nxt    = OP_FB;
        end
      end
      S_MGO: begin
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        unique case (op_r)
          OP_FB: begin
            op_nxt    = OP_STG;
            state_nxt = S_MGO;
          end
          OP_STG: begin
            if (stg_last) begin
              op_nxt = OP_DRY;
            end
            state_nxt = S_MGO;
          end
          OP_DRY: begin
            op_nxt    = OP_WET;
            state_nxt = S_MGO;
          end
          OP_WET: begin
            // hold until the result register is free
            if (out_free) begin
              op_nxt    = OP_SWEEP;
              state_nxt = S_MGO;
            end
          end
          OP_SWEEP: begin
            state_nxt = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_low_r  <= SWEEP_LOW_RST;
      sweep_high_r <= SWEEP_HIGH_RST;
      step_up_r    <= STEP_UP_RST;
      step_down_r  <= STEP_DOWN_RST;
      fb_gain_r    <= $signed(GAIN_ONE);
      dry_gain_r   <= $signed(GAIN_ONE);
      wet_gain_r   <= $signed(GAIN_ONE);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SWEEP_LOW:       sweep_low_r  <= cfg_wdata;
        CFG_SWEEP_HIGH:      sweep_high_r <= cfg_wdata;
        CFG_SWEEP_STEP_UP:   step_up_r    <= cfg_wdata;
        CFG_SWEEP_STEP_DOWN: step_down_r  <= cfg_wdata;
        CFG_FEEDBACK_GAIN:   fb_gain_r    <= $signed(cfg_wdata);
        CFG_DRY_GAIN:        dry_gain_r   <= $signed(cfg_wdata);
        CFG_WET_GAIN:        wet_gain_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // filter state and sweep; a lower bound write restarts the sweep and clears
  // the allpass state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        so_r[i]  <= '0;
        spi_r[i] <= '0;
      end
      p_r       <= SWEEP_LOW_RST;
      desc_r    <= 1'b0;
      stg_cnt_r <= '0;
    end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_SWEEP_LOW)) begin
      for (int i = 0; i < STAGES; i++) begin
        so_r[i]  <= '0;
        spi_r[i] <= '0;
      end
      p_r    <= cfg_wdata;
      desc_r <= 1'b0;
    end else if (wb_fire) begin
      case (op_r)
        OP_FB: begin
          stg_cnt_r <= '0;
        end
        OP_STG: begin
          // rotate so the next stage comes to position 0
          for (int i = 0; i < STAGES - 1; i++) begin
            so_r[i]  <= so_r[i+1];
            spi_r[i] <= spi_r[i+1];
          end
          so_r[STAGES-1]  <= wb_sat;
          spi_r[STAGES-1] <= v_r;
          stg_cnt_r       <= stg_cnt_r + 1'b1;
        end
        OP_SWEEP: begin
          p_r <= np;
          if (np > sweep_high_r) begin
            desc_r <= 1'b1;
          end else if (np < sweep_low_r) begin
            desc_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_sample_in;
    end
    if ((state_r == S_DIV) && div_done) begin
      k_r <= p_over ? -$signed(kq) : $signed(kq);
    end
    if (state_r == S_RND) begin
      rnd_r <= rnd_add[PROD_W-1:Q_FRAC];
    end
    if (wb_fire) begin
      case (op_r)
        OP_FB:   v_r        <= wb_sat;
        OP_STG:  v_r        <= wb_sat;
        OP_DRY:  dry_prod_r <= mul_prod;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_fire && (op_r == OP_WET)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire && (op_r == OP_WET)) begin
      out_sample_r <= wb_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DIV)
    else $error("accepted item did not start the coefficient divide");

  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB && op_r == OP_WET))
    else $error("result offered outside the mix write-back");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished while the sequencer was not waiting");

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MWAIT)
    else $error("multiplier finished while the sequencer was not waiting");

endmodule

`default_nettype wire
